>>> rtl/core/wva_pkg.sv
// ----------------------------------------------------------------------------
// wva_pkg
// Shared widths, constants and types of the wind vane averager.
// ----------------------------------------------------------------------------
package wva_pkg;

    localparam int SAMPLE_W = 12;
    localparam int SEQ_W    = 16;
    localparam int SCALE_W  = 16;
    localparam int OFFSET_W = 9;
    localparam int RUN_W    = 8;
    localparam int EPI_W    = 3;
    localparam int AVG_W    = 19;
    localparam int HEAD_W   = 17;
    localparam int CFG_W    = 16;

    // reset values of the configuration registers
    localparam logic [SCALE_W-1:0]  SCALE_RST   = 16'd5328;
    localparam logic [OFFSET_W-1:0] OFFSET_RST  = 9'd32;
    localparam logic [RUN_W-1:0]    RUN_LIM_RST = 8'd100;
    localparam logic [EPI_W-1:0]    EPI_LIM_RST = 3'd4;

    localparam logic [RUN_W-1:0] RUN_MAX = '1;
    localparam logic [EPI_W-1:0] EPI_MAX = '1;

    typedef enum logic [1:0] {
        CFG_SCALE   = 2'd0,
        CFG_OFFSET  = 2'd1,
        CFG_RUN_LIM = 2'd2,
        CFG_EPI_LIM = 2'd3
    } cfg_idx_t;

    // per-block status that travels with the block sum
    typedef struct packed {
        logic             fatal;
        logic [SEQ_W-1:0] seq;
    } blk_info_t;

endpackage

>>> rtl/core/wva_accum.sv
// ----------------------------------------------------------------------------
// wva_accum
// Block accumulator with error-run, episode and sequence tracking.
// ----------------------------------------------------------------------------
module wva_accum #(
    parameter int SAMPLES_PER_BLOCK = 64,
    parameter int SUM_W             = 19
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [wva_pkg::SAMPLE_W-1:0]  sample_value,
    input  logic                          sample_failed,
    input  logic [wva_pkg::RUN_W-1:0]     run_limit,
    input  logic [wva_pkg::EPI_W-1:0]     epi_limit,
    input  logic                          blk_ready,
    output logic                          blk_valid,
    output logic signed [SUM_W-1:0]       blk_sum,
    output wva_pkg::blk_info_t            blk_info
);
    import wva_pkg::*;

    localparam int IDX_W = $clog2(SAMPLES_PER_BLOCK);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES_PER_BLOCK - 1);
    localparam logic signed [SUM_W-1:0] ERR_SUM = SUM_W'(-SAMPLES_PER_BLOCK);

    logic signed [SUM_W-1:0] sum_reg, sum_next, sample_ext;
    logic [IDX_W-1:0]        idx_reg;
    logic [RUN_W-1:0]        run_reg, run_next;
    logic [EPI_W-1:0]        epi_reg, epi_next;
    logic [SEQ_W-1:0]        seq_reg, seq_next;
    logic                    blk_valid_reg;
    logic signed [SUM_W-1:0] blk_sum_reg;
    blk_info_t               blk_info_reg;
    logic                    slot_ready, accept, last, err;

    assign slot_ready = !blk_valid_reg || blk_ready;
    assign last       = (idx_reg == IDX_LAST);
    assign in_ready   = !last || slot_ready;
    assign accept     = in_valid && in_ready;

    // failed read counts as -1
    assign sample_ext = sample_failed ? '1 : SUM_W'(sample_value);
    assign sum_next   = sum_reg + sample_ext;
    assign err        = (sum_next == ERR_SUM);

    always_comb
    begin
        run_next = run_reg;
        epi_next = epi_reg;
        if (err)
        begin
            if (run_reg != RUN_MAX)
                run_next = run_reg + 1'b1;
            if (run_reg == '0 && epi_reg != EPI_MAX)
                epi_next = epi_reg + 1'b1;
        end
        else
        begin
            run_next = '0;
        end
    end

    assign seq_next = seq_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            idx_reg       <= '0;
            run_reg       <= '0;
            epi_reg       <= '0;
            seq_reg       <= '0;
            blk_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (last)
                begin
                    sum_reg <= '0;
                    idx_reg <= '0;
                    run_reg <= run_next;
                    epi_reg <= epi_next;
                    seq_reg <= seq_next;
                end
                else
                begin
                    sum_reg <= sum_next;
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            if (slot_ready)
                blk_valid_reg <= accept && last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_ready && accept && last)
        begin
            blk_sum_reg        <= sum_next;
            blk_info_reg.fatal <= (run_next >= run_limit) || (epi_next >= epi_limit);
            blk_info_reg.seq   <= seq_next;
        end
    end

    assign blk_valid = blk_valid_reg;
    assign blk_sum   = blk_sum_reg;
    assign blk_info  = blk_info_reg;

endmodule

>>> rtl/core/wva_heading.sv
// ----------------------------------------------------------------------------
// wva_heading
// Heading pipeline: scale multiply, divide by block length through a
// reciprocal, offset, wrap and clamp, then the result register.
// ----------------------------------------------------------------------------
module wva_heading #(
    parameter int SAMPLES_PER_BLOCK = 64,
    parameter int SUM_W             = 19
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          blk_valid,
    output logic                          blk_ready,
    input  logic signed [SUM_W-1:0]       blk_sum,
    input  wva_pkg::blk_info_t            blk_info,
    input  logic [wva_pkg::SCALE_W-1:0]   scale,
    input  logic [wva_pkg::OFFSET_W-1:0]  offset,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [wva_pkg::AVG_W-1:0]     res_average,
    output logic [wva_pkg::HEAD_W-1:0]    res_heading,
    output wva_pkg::blk_info_t            res_info
);
    import wva_pkg::*;

    localparam int PROD_W = SUM_W + SCALE_W + 1;
    localparam int TW     = PROD_W - 8;
    // quotient is only needed inside a window around the circle, so the
    // dividend is clamped and biased nonnegative before the reciprocal
    localparam int T_BIAS_I = SAMPLES_PER_BLOCK * 131072;
    localparam int T_HI_I   = SAMPLES_PER_BLOCK * 262144;
    localparam logic signed [TW-1:0] T_LO   = TW'(-T_BIAS_I);
    localparam logic signed [TW-1:0] T_HI   = TW'(T_HI_I);
    localparam logic signed [TW-1:0] T_BIAS = TW'(T_BIAS_I);
    localparam int UW   = $clog2(3 * T_BIAS_I + 1);
    localparam int K    = UW + $clog2(SAMPLES_PER_BLOCK);
    localparam int MW   = UW + 1;
    localparam int QMW  = UW + MW;
    localparam int QB_W = 19;
    localparam logic [MW-1:0] RECIP =
        MW'(((longint'(1) <<< K) + SAMPLES_PER_BLOCK - 1) / SAMPLES_PER_BLOCK);
    localparam int HW = 21;
    localparam logic signed [HW-1:0] H_BIAS = 21'sd131072;
    localparam logic signed [HW-1:0] FULL   = 21'sd92160;

    logic                    st2_valid_reg, st3_valid_reg, out_valid_reg;
    logic                    rdy_out, rdy3, rdy2;
    logic signed [PROD_W-1:0] prod_next, prod_reg;
    logic [AVG_W-1:0]        avg2_reg, avg3_reg, avg_out_reg;
    blk_info_t               info2_reg, info3_reg, info_out_reg;
    logic signed [TW-1:0]    t_val, t_clamp, t_biased;
    logic [UW-1:0]           u_val;
    logic [QMW-1:0]          qm_next, qm_reg;
    logic [QB_W-1:0]         q_biased;
    logic signed [HW-1:0]    h_raw, h_wrap, h_sat;
    logic [HEAD_W-1:0]       head_out_reg;

    assign rdy_out   = !out_valid_reg || res_ready;
    assign rdy3      = !st3_valid_reg || rdy_out;
    assign rdy2      = !st2_valid_reg || rdy3;
    assign blk_ready = rdy2;

    // stage 2: sum times scale
    assign prod_next = $signed({{(SCALE_W + 1){blk_sum[SUM_W-1]}}, blk_sum})
                     * $signed({{SUM_W{1'b0}}, 1'b0, scale});

    // stage 3: floor by 256, clamp, bias, multiply by reciprocal of block length
    assign t_val    = prod_reg[PROD_W-1:8];
    assign t_clamp  = (t_val < T_LO) ? T_LO : ((t_val > T_HI) ? T_HI : t_val);
    assign t_biased = t_clamp + T_BIAS;
    assign u_val    = t_biased[UW-1:0];
    assign qm_next  = QMW'(u_val) * QMW'(RECIP);

    // stage 4: remove bias, add offset, wrap once, clamp
    assign q_biased = qm_reg[K +: QB_W];
    assign h_raw    = $signed({2'b00, q_biased}) - H_BIAS
                    + $signed({4'b0000, offset, 8'h00});
    assign h_wrap   = (h_raw > FULL) ? (h_raw - FULL) : h_raw;
    assign h_sat    = (h_wrap < 0) ? '0 : ((h_wrap > FULL) ? FULL : h_wrap);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy2)
                st2_valid_reg <= blk_valid;
            if (rdy3)
                st3_valid_reg <= st2_valid_reg;
            if (rdy_out)
                out_valid_reg <= st3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && blk_valid)
        begin
            prod_reg  <= prod_next;
            avg2_reg  <= AVG_W'(blk_sum);
            info2_reg <= blk_info;
        end
        if (rdy3 && st2_valid_reg)
        begin
            qm_reg    <= qm_next;
            avg3_reg  <= avg2_reg;
            info3_reg <= info2_reg;
        end
        if (rdy_out && st3_valid_reg)
        begin
            // a fatal block reports zero average and heading
            avg_out_reg  <= info3_reg.fatal ? '0 : avg3_reg;
            head_out_reg <= info3_reg.fatal ? '0 : h_sat[HEAD_W-1:0];
            info_out_reg <= info3_reg;
        end
    end

    assign res_valid   = out_valid_reg;
    assign res_average = avg_out_reg;
    assign res_heading = head_out_reg;
    assign res_info    = info_out_reg;

endmodule

>>> rtl/core/wind_vane_average_and_fault.sv
// ----------------------------------------------------------------------------
// wind_vane_average_and_fault
// Wind vane block averager with heading conversion and sensor fault flag.
// ----------------------------------------------------------------------------
// path: the word that completes a block loads the block register on the edge
//   that accepts it, then passes the scale multiply register, the reciprocal
//   multiply register and the result reg before it shows on m_axis
// throughput: one sample per cycle unless a held m_axis backs up every stage,
//   one result per SAMPLES_PER_BLOCK samples, set by the accumulator and the fully pipelined heading path
// reset: rst_n clears sums, counters, run and episode tracking and all valid
//   flags; configuration registers return to their defaults
module wind_vane_average_and_fault #(
    parameter int SAMPLES_PER_BLOCK = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] sample_value
    input  logic        s_axis_tuser,   // [0] sample_failed
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [18:0] average_x64, [35:19] heading_q8,
                                        // [51:36] sequence_res
    output logic        m_axis_tuser,   // [0] fatal
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import wva_pkg::*;

    localparam int SUM_W = $clog2(SAMPLES_PER_BLOCK) + SAMPLE_W + 1;

    logic [SCALE_W-1:0]      scale_reg;
    logic [OFFSET_W-1:0]     offset_reg;
    logic [RUN_W-1:0]        run_lim_reg;
    logic [EPI_W-1:0]        epi_lim_reg;
    logic                    blk_valid, blk_ready;
    logic signed [SUM_W-1:0] blk_sum;
    blk_info_t               blk_info, res_info;
    logic [AVG_W-1:0]        res_average;
    logic [HEAD_W-1:0]       res_heading;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg   <= SCALE_RST;
            offset_reg  <= OFFSET_RST;
            run_lim_reg <= RUN_LIM_RST;
            epi_lim_reg <= EPI_LIM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SCALE:   scale_reg   <= cfg_data[SCALE_W-1:0];
                CFG_OFFSET:  offset_reg  <= cfg_data[OFFSET_W-1:0];
                CFG_RUN_LIM: run_lim_reg <= cfg_data[RUN_W-1:0];
                CFG_EPI_LIM: epi_lim_reg <= cfg_data[EPI_W-1:0];
                default:     ;
            endcase
        end
    end

    wva_accum #(
        .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK),
        .SUM_W             (SUM_W)
    ) u_accum (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .sample_value  (s_axis_tdata[SAMPLE_W-1:0]),
        .sample_failed (s_axis_tuser),
        .run_limit     (run_lim_reg),
        .epi_limit     (epi_lim_reg),
        .blk_ready     (blk_ready),
        .blk_valid     (blk_valid),
        .blk_sum       (blk_sum),
        .blk_info      (blk_info)
    );

    wva_heading #(
        .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK),
        .SUM_W             (SUM_W)
    ) u_heading (
        .clk         (clk),
        .rst_n       (rst_n),
        .blk_valid   (blk_valid),
        .blk_ready   (blk_ready),
        .blk_sum     (blk_sum),
        .blk_info    (blk_info),
        .scale       (scale_reg),
        .offset      (offset_reg),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_average (res_average),
        .res_heading (res_heading),
        .res_info    (res_info)
    );

    assign m_axis_tdata = {4'b0000, res_info.seq, res_heading, res_average};
    assign m_axis_tuser = res_info.fatal;

    // input only stalls when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while pipeline has room");

    a_fatal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[35:0] == 36'd0))
        else $error("fatal word carries nonzero average or heading");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[35:19] <= 17'd92160))
        else $error("heading beyond full circle");

endmodule

>>> tb/sv/wind_vane_average_and_fault_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wind_vane_average_and_fault_tb
// Self-checking bench for the wind vane block averager. Whole blocks of
// samples go in on s_axis; a block model kept here folds every accepted word
// and predicts the block sum, heading, fault flag and sequence number of each
// completed block. A short scripted list of blocks covers the corner cases,
// then randomized phases under changing register settings follow, with random
// stalls on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module wind_vane_average_and_fault_tb;

    import wva_pkg::*;

    localparam int  BLOCK_LEN     = 64;
    localparam int  SUM_SHIFT     = $clog2(BLOCK_LEN * 256);
    localparam int  FULL_CIRCLE   = 360 * 256;
    localparam int  N_ITEMS       = 1850;
    localparam int  N_ROWS        = 17;
    localparam int  TAIL_BLKS     = 3;
    localparam int  RAND_BLKS     = (N_ITEMS + BLOCK_LEN / 2) / BLOCK_LEN - N_ROWS - TAIL_BLKS;
    localparam int  HOLD_BLKS     = 6;
    localparam int  DRAIN_CYCLES  = 8;
    localparam int  LONG_HOLD     = 800;
    localparam int  IDLE_LIMIT    = 4000;

    typedef enum int {
        BLK_STEADY,
        BLK_DEAD,
        BLK_ONE_LIVE,
        BLK_ONE_DEAD,
        BLK_ALTERNATE,
        BLK_NOISY,
        BLK_EDGES
    } block_shape_e;

    typedef struct packed {
        logic [AVG_W-1:0]  avg;
        logic [HEAD_W-1:0] heading;
        logic              fatal;
        logic [SEQ_W-1:0]  seq;
    } vane_result_t;

    typedef struct {
        block_shape_e      shape;
        logic [SAMPLE_W-1:0] value;
        bit                cfg_we;
        cfg_idx_t          cfg_reg;
        logic [CFG_W-1:0]  cfg_val;
        bit                typed;
        logic [AVG_W-1:0]  avg;
        logic [HEAD_W-1:0] heading;
        logic              fatal;
    } vane_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // block model state and its copy of the registers
    logic [SCALE_W-1:0]  mdl_scale;
    logic [OFFSET_W-1:0] mdl_offset;
    logic [RUN_W-1:0]    mdl_run_lim;
    logic [EPI_W-1:0]    mdl_epi_lim;
    longint              acc_sum;
    int                  acc_count;
    logic [RUN_W-1:0]    err_run;
    logic [EPI_W-1:0]    err_epis;
    logic [SEQ_W-1:0]    blk_count;

    vane_result_t pending_blocks[$];
    vane_result_t typed_res;
    bit           use_typed;
    int           mismatches;
    int           idle_cycles;
    bit           gaps_on;
    bit           stall_on;
    bit           no_idle;
    bit           hold_req;

    vane_row_t    script_rows [N_ROWS];

    wind_vane_average_and_fault #(
        .SAMPLES_PER_BLOCK(BLOCK_LEN)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    function automatic logic [HEAD_W-1:0] vane_heading(input longint sum);
        longint h;
        // divide by block length and Q8 in one floor shift
        h = (sum * longint'(mdl_scale)) >>> SUM_SHIFT;
        h += longint'(mdl_offset) * 256;
        if (h > FULL_CIRCLE)
            h -= FULL_CIRCLE;
        if (h < 0)
            h = 0;
        if (h > FULL_CIRCLE)
            h = FULL_CIRCLE;
        return h[HEAD_W-1:0];
    endfunction

    task automatic fold_sample(input logic [SAMPLE_W-1:0] value, input bit failed,
                               output bit done, output vane_result_t res);
        longint sum;
        bit     err;
        bit     fatal;
        done = 1'b0;
        res  = '0;
        if (failed)
            acc_sum -= 1;
        else
            acc_sum += longint'(value);
        acc_count++;
        if (acc_count < BLOCK_LEN)
            return;
        sum       = acc_sum;
        acc_sum   = 0;
        acc_count = 0;
        err = (sum == -BLOCK_LEN);
        if (err)
        begin
            if (err_run != RUN_MAX)
                err_run++;
            if (err_run == 1 && err_epis != EPI_MAX)
                err_epis++;
        end
        else
            err_run = '0;
        fatal = (err_run >= mdl_run_lim) || (err_epis >= mdl_epi_lim);
        blk_count++;
        done      = 1'b1;
        res.fatal = fatal;
        res.seq   = blk_count;
        if (!fatal)
        begin
            res.avg     = sum[AVG_W-1:0];
            res.heading = vane_heading(sum);
        end
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit failed);
        bit           done;
        vane_result_t res;
        if (gaps_on && !no_idle && $urandom_range(0, 5) == 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, value};
        s_axis_tuser  <= failed;
        do @(posedge clk); while (!s_axis_tready);
        fold_sample(value, failed, done, res);
        if (done)
        begin
            if (use_typed)
            begin
                res.avg     = typed_res.avg;
                res.heading = typed_res.heading;
                res.fatal   = typed_res.fatal;
            end
            pending_blocks.push_back(res);
        end
    endtask

    task automatic send_block(input block_shape_e shape, input logic [SAMPLE_W-1:0] value);
        int                  pos;
        int                  fail_rate;
        logic [SAMPLE_W-1:0] v;
        bit                  f;
        pos       = $urandom_range(0, BLOCK_LEN - 1);
        fail_rate = $urandom_range(0, 4);
        for (int i = 0; i < BLOCK_LEN; i++)
        begin
            v = SAMPLE_W'($urandom_range(0, 4095));
            f = 1'b0;
            case (shape)
                BLK_STEADY:    v = value;
                BLK_DEAD:      f = 1'b1;
                BLK_ONE_LIVE:
                begin
                    f = (i != pos);
                    if (!f)
                        v = value;
                end
                BLK_ONE_DEAD:
                begin
                    f = (i == pos);
                    v = value;
                end
                BLK_ALTERNATE: v = i[0] ? ~value : value;
                BLK_NOISY:     f = ($urandom_range(0, 15) < fail_rate);
                BLK_EDGES:
                begin
                    case ($urandom_range(0, 4))
                        0: v = '0;
                        1: v = 12'd1;
                        2: v = 12'd4094;
                        3: v = '1;
                        default: ;
                    endcase
                    f = ($urandom_range(0, 31) == 0);
                end
                default: ;
            endcase
            send_sample(v, f);
        end
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SCALE:   mdl_scale   = data[SCALE_W-1:0];
            CFG_OFFSET:  mdl_offset  = data[OFFSET_W-1:0];
            CFG_RUN_LIM: mdl_run_lim = data[RUN_W-1:0];
            CFG_EPI_LIM: mdl_epi_lim = data[EPI_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop offering, let every block come out, then let the pipe settle
    task automatic drain_blocks;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic pick_settings;
        logic [CFG_W-1:0] s;
        case ($urandom_range(0, 3))
            0: s = '0;
            1: s = '1;
            default: s = CFG_W'($urandom_range(0, 65535));
        endcase
        write_reg(CFG_SCALE, s);
        case ($urandom_range(0, 3))
            0: s = 16'd0;
            1: s = 16'd360;
            default: s = CFG_W'($urandom_range(0, 360));
        endcase
        write_reg(CFG_OFFSET, s);
        case ($urandom_range(0, 3))
            0: s = 16'd1;
            1: s = 16'd255;
            2: s = CFG_W'($urandom_range(1, 4));
            default: s = CFG_W'($urandom_range(1, 255));
        endcase
        write_reg(CFG_RUN_LIM, s);
        s = ($urandom_range(0, 2) == 0) ? CFG_W'($urandom_range(1, 7)) : 16'd7;
        write_reg(CFG_EPI_LIM, s);
    endtask

    task automatic random_block(input bit any_errors);
        int  r;
        bit  allow_dead;
        // new error episodes are rationed so the fault flag does not latch early
        allow_dead = any_errors || err_epis < 5 || err_run != 0;
        r = $urandom_range(0, 15);
        if (allow_dead && (r < 2 || (err_run != 0 && r < 8)))
            send_block(BLK_DEAD, '0);
        else if (r < 10 && r >= 8)
            send_block(BLK_ONE_LIVE, SAMPLE_W'($urandom_range(0, 4095)));
        else if (r == 10)
            send_block(BLK_ONE_DEAD, SAMPLE_W'($urandom_range(0, 4095)));
        else if (r < 13)
            send_block(BLK_EDGES, '0);
        else
            send_block(BLK_NOISY, '0);
    endtask

    // output side: random stall bursts, one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (stall_on && !no_idle && $urandom_range(0, 4) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        vane_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_blocks.size() == 0)
                note_mismatch($sformatf("word with no block pending, seq %0d",
                                        m_axis_tdata[51:36]));
            else
            begin
                want = pending_blocks.pop_front();
                if (m_axis_tdata[18:0] !== want.avg)
                    note_mismatch($sformatf("seq %0d average_x64 %0d, want %0d", want.seq,
                                            $signed(m_axis_tdata[18:0]), $signed(want.avg)));
                if (m_axis_tdata[35:19] !== want.heading)
                    note_mismatch($sformatf("seq %0d heading_q8 %0d, want %0d", want.seq,
                                            m_axis_tdata[35:19], want.heading));
                if (m_axis_tuser !== want.fatal)
                    note_mismatch($sformatf("seq %0d fatal %0b, want %0b", want.seq,
                                            m_axis_tuser, want.fatal));
                if (m_axis_tdata[51:36] !== want.seq)
                    note_mismatch($sformatf("sequence_res %0d, want %0d",
                                            m_axis_tdata[51:36], want.seq));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("** wind_vane_average_and_fault: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int rand_blks;
        int n_blks;
        int phase_no;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_SCALE;
        cfg_data      = '0;
        mdl_scale     = SCALE_RST;
        mdl_offset    = OFFSET_RST;
        mdl_run_lim   = RUN_LIM_RST;
        mdl_epi_lim   = EPI_LIM_RST;
        acc_sum       = 0;
        acc_count     = 0;
        err_run       = '0;
        err_epis      = '0;
        blk_count     = '0;
        use_typed     = 1'b0;
        typed_res     = '0;
        mismatches    = 0;
        idle_cycles   = 0;
        gaps_on       = 1'b1;
        stall_on      = 1'b1;
        no_idle       = 1'b0;
        hold_req      = 1'b0;

        // shape, value, register write, typed result (avg, heading, fatal)
        script_rows = '{
            '{BLK_STEADY,    12'd0,    0, CFG_SCALE,   16'd0,     1, 19'd0,      17'd8192,  1'b0},
            '{BLK_STEADY,    12'd4095, 0, CFG_SCALE,   16'd0,     0, '0, '0, 1'b0},
            '{BLK_ALTERNATE, 12'hAAA,  0, CFG_SCALE,   16'd0,     0, '0, '0, 1'b0},
            '{BLK_DEAD,      12'd0,    0, CFG_SCALE,   16'd0,     0, '0, '0, 1'b0},
            '{BLK_ONE_LIVE,  12'd4095, 0, CFG_SCALE,   16'd0,     0, '0, '0, 1'b0},
            '{BLK_ONE_DEAD,  12'd4095, 0, CFG_SCALE,   16'd0,     0, '0, '0, 1'b0},
            '{BLK_STEADY,    12'd4095, 1, CFG_SCALE,   16'd0,     1, 19'd262080, 17'd8192,  1'b0},
            '{BLK_STEADY,    12'd0,    1, CFG_OFFSET,  16'd360,   1, 19'd0,      17'd92160, 1'b0},
            '{BLK_STEADY,    12'd1,    1, CFG_OFFSET,  16'd0,     1, 19'd64,     17'd0,     1'b0},
            '{BLK_STEADY,    12'd4095, 1, CFG_SCALE,   16'hFFFF,  0, '0, '0, 1'b0},
            '{BLK_ONE_LIVE,  12'd0,    1, CFG_OFFSET,  16'd360,   0, '0, '0, 1'b0},
            '{BLK_DEAD,      12'd0,    1, CFG_RUN_LIM, 16'd1,     1, 19'd0,      17'd0,     1'b1},
            '{BLK_DEAD,      12'd0,    0, CFG_SCALE,   16'd0,     1, 19'd0,      17'd0,     1'b1},
            '{BLK_DEAD,      12'd0,    1, CFG_RUN_LIM, 16'd255,   0, '0, '0, 1'b0},
            '{BLK_STEADY,    12'd2048, 0, CFG_SCALE,   16'd0,     0, '0, '0, 1'b0},
            '{BLK_STEADY,    12'd100,  1, CFG_EPI_LIM, 16'd1,     1, 19'd0,      17'd0,     1'b1},
            '{BLK_STEADY,    12'd100,  1, CFG_EPI_LIM, 16'd7,     0, '0, '0, 1'b0}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script_rows[i])
        begin
            if (script_rows[i].cfg_we)
            begin
                drain_blocks();
                write_reg(script_rows[i].cfg_reg, script_rows[i].cfg_val);
            end
            use_typed         = script_rows[i].typed;
            typed_res.avg     = script_rows[i].avg;
            typed_res.heading = script_rows[i].heading;
            typed_res.fatal   = script_rows[i].fatal;
            send_block(script_rows[i].shape, script_rows[i].value);
            use_typed = 1'b0;
        end

        rand_blks  = 0;
        phase_no   = 0;
        while (rand_blks < RAND_BLKS)
        begin
            drain_blocks();
            pick_settings();
            gaps_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            n_blks   = $urandom_range(3, 7);
            // short first phase leaves room for the hold-off phase
            if (phase_no == 0)
                n_blks = $urandom_range(1, 3);
            if (phase_no == 1)
            begin
                // sender keeps offering while the output is held off
                gaps_on  = 1'b0;
                hold_req = 1'b1;
                n_blks   = HOLD_BLKS;
            end
            if (n_blks > RAND_BLKS - rand_blks)
                n_blks = RAND_BLKS - rand_blks;
            repeat (n_blks)
            begin
                random_block(1'b0);
                rand_blks++;
            end
            phase_no++;
        end

        // closing phase at full rate, error episodes no longer rationed
        drain_blocks();
        pick_settings();
        no_idle = 1'b1;
        repeat (TAIL_BLKS)
            random_block(1'b1);
        drain_blocks();

        if (mismatches == 0)
            $display("** wind_vane_average_and_fault: PASSED **");
        else
            $display("** wind_vane_average_and_fault: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/wva_pkg.sv
rtl/core/wva_accum.sv
rtl/core/wva_heading.sv
rtl/core/wind_vane_average_and_fault.sv
tb/sv/wind_vane_average_and_fault_tb.sv
